@@ hdl/bsp_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the byte stack.
package bsp_pkg;

  localparam int unsigned Depth = 32;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned DataW = 8;

  localparam logic [CountW-1:0] CountDepth = CountW'(Depth);
  localparam logic [CountW-1:0] CapReset = CountW'(32);

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_BADPOS    = 2'd3;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

@@ hdl/byte_stack_with_peek.sv @@
// Top level of the byte stack: joins the controller and the datapath.
//
// Usage: a LIFO store of bytes with push, pop and peek-by-depth commands.
// Input channel: in_valid_i / in_stall_o carry one item (command_i, value_i,
// position_i); an item is taken at a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry one result item per input
// item: byte read, status, empty/full flags, count, top and bottom bytes.
// Capacity register: cfg_we_i writes cfg_wdata_i; zero acts as one and values
// above the depth saturate to it. Write it only while the block is idle.
// Path to the result register: execute with the memory access, then load of
// the result. The input stalls until the result is loaded, so a new item is
// taken only once the last one is through; the controller walks each item
// through the single read port of the entry memory.
// Reset: the count clears, the capacity returns to 32, no result is pending.
// The entry memory is not cleared; no entry at or above the count reaches a result.
// Receiver stall: the result register holds its item; the next item may be
// accepted meanwhile and waits finished in the datapath until the result
// register frees up, with the input stalled behind it.
module byte_stack_with_peek (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [bsp_pkg::DataW-1:0]           value_i,
  input  logic [bsp_pkg::CountW-1:0]          position_i,
  input  logic                                cfg_we_i,
  input  logic [bsp_pkg::CountW-1:0]          cfg_wdata_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bsp_pkg::DataW-1:0]           data_o,
  output logic [1:0]                          status_o,
  output logic                                empty_res_o,
  output logic                                full_res_o,
  output logic [bsp_pkg::CountW-1:0]          count_o,
  output logic [bsp_pkg::DataW-1:0]           top_item_o,
  output logic [bsp_pkg::DataW-1:0]           bottom_item_o
);

  // command and status between controller and datapath
  bsp_pkg::ctrl_cmd_t  ctrl_cmd;
  bsp_pkg::dp_status_t dp_sts;

  bsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  bsp_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .sts_o         (dp_sts),
    .command_i     (command_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_o        (data_o),
    .status_o      (status_o),
    .empty_res_o   (empty_res_o),
    .full_res_o    (full_res_o),
    .count_o       (count_o),
    .top_item_o    (top_item_o),
    .bottom_item_o (bottom_item_o)
  );

endmodule

@@ hdl/bsp_ctrl.sv @@
// Controller state machine: sequences capture, execute and result load of one item.
module bsp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bsp_pkg::dp_status_t sts_i,
  output bsp_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LOAD = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_stall_o    = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/bsp_datapath.sv @@
// Datapath: entry memory, count, top/bottom bytes, capacity and the output register.
module bsp_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bsp_pkg::ctrl_cmd_t                  cmd_i,
  output bsp_pkg::dp_status_t                 sts_o,
  input  logic [1:0]                          command_i,
  input  logic [bsp_pkg::DataW-1:0]           value_i,
  input  logic [bsp_pkg::CountW-1:0]          position_i,
  input  logic                                cfg_we_i,
  input  logic [bsp_pkg::CountW-1:0]          cfg_wdata_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bsp_pkg::DataW-1:0]           data_o,
  output logic [1:0]                          status_o,
  output logic                                empty_res_o,
  output logic                                full_res_o,
  output logic [bsp_pkg::CountW-1:0]          count_o,
  output logic [bsp_pkg::DataW-1:0]           top_item_o,
  output logic [bsp_pkg::DataW-1:0]           bottom_item_o
);

  logic [bsp_pkg::DataW-1:0]  mem_q [bsp_pkg::Depth];
  logic [bsp_pkg::DataW-1:0]  rd_q;

  logic [1:0]                 cmd_q;
  logic [bsp_pkg::DataW-1:0]  val_q;
  logic [bsp_pkg::CountW-1:0] pos_q;
  logic [bsp_pkg::CountW-1:0] cap_q, count_q, count_d;
  logic [bsp_pkg::DataW-1:0]  top_q, top_d, bottom_q, bottom_d;
  logic [bsp_pkg::DataW-1:0]  data_q, data_d;
  logic [1:0]                 res_status_q, res_status_d;
  logic                       use_rd_q, use_rd_d;
  logic                       pop_ok_q, pop_ok_d;

  logic                       mem_we, mem_re;
  logic [bsp_pkg::AddrW-1:0]  mem_waddr, mem_raddr;
  logic [bsp_pkg::CountW-1:0] cap_eff, peek_idx;
  logic                       is_empty, is_full;

  logic                       out_valid_q;
  logic [bsp_pkg::DataW-1:0]  out_data_q, out_top_q, out_bottom_q;
  logic [1:0]                 out_status_q;
  logic                       out_empty_q, out_full_q;
  logic [bsp_pkg::CountW-1:0] out_count_q;
  logic [bsp_pkg::DataW-1:0]  top_next;

  // saturate capacity into 1..Depth
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = bsp_pkg::CountW'(1);
    end else if (cap_q > bsp_pkg::CountDepth) begin
      cap_eff = bsp_pkg::CountDepth;
    end else begin
      cap_eff = cap_q;
    end
  end

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q >= cap_eff);
  assign peek_idx = count_q - pos_q;

  always_comb begin
    count_d      = count_q;
    top_d        = top_q;
    bottom_d     = bottom_q;
    data_d       = '0;
    res_status_d = bsp_pkg::ST_OK;
    use_rd_d     = 1'b0;
    pop_ok_d     = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = count_q[bsp_pkg::AddrW-1:0];
    mem_raddr    = count_q[bsp_pkg::AddrW-1:0] - bsp_pkg::AddrW'(2);
    unique case (cmd_q)
      bsp_pkg::CMD_PUSH: begin
        if (is_full) begin
          res_status_d = bsp_pkg::ST_OVERFLOW;
        end else begin
          mem_we  = cmd_i.exec;
          count_d = count_q + bsp_pkg::CountW'(1);
          top_d   = val_q;
          if (is_empty) begin
            bottom_d = val_q;
          end
        end
      end
      bsp_pkg::CMD_POP: begin
        if (is_empty) begin
          res_status_d = bsp_pkg::ST_UNDERFLOW;
        end else begin
          // fetch the entry below the top as the new top
          mem_re   = cmd_i.exec;
          count_d  = count_q - bsp_pkg::CountW'(1);
          data_d   = top_q;
          pop_ok_d = 1'b1;
        end
      end
      bsp_pkg::CMD_PEEK: begin
        mem_raddr = peek_idx[bsp_pkg::AddrW-1:0];
        if (is_empty) begin
          res_status_d = bsp_pkg::ST_UNDERFLOW;
        end else if (pos_q == '0 || pos_q > count_q) begin
          res_status_d = bsp_pkg::ST_BADPOS;
        end else begin
          mem_re   = cmd_i.exec;
          use_rd_d = 1'b1;
        end
      end
      bsp_pkg::CMD_NOP: begin
        res_status_d = bsp_pkg::ST_OK;
      end
      default: res_status_d = bsp_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= val_q;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= command_i;
      val_q <= value_i;
      pos_q <= position_i;
    end
    if (cmd_i.exec) begin
      data_q       <= data_d;
      res_status_q <= res_status_d;
      use_rd_q     <= use_rd_d;
      pop_ok_q     <= pop_ok_d;
      bottom_q     <= bottom_d;
    end
    if (cmd_i.exec) begin
      top_q <= top_d;
    end else if (cmd_i.load && pop_ok_q) begin
      top_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= bsp_pkg::CapReset;
    end else begin
      if (cmd_i.exec) begin
        count_q <= count_d;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  assign top_next = pop_ok_q ? rd_q : top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q   <= use_rd_q ? rd_q : data_q;
      out_status_q <= res_status_q;
      out_empty_q  <= is_empty;
      out_full_q   <= is_full;
      out_count_q  <= count_q;
      out_top_q    <= is_empty ? '0 : top_next;
      out_bottom_q <= is_empty ? '0 : bottom_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign data_o        = out_data_q;
  assign status_o      = out_status_q;
  assign empty_res_o   = out_empty_q;
  assign full_res_o    = out_full_q;
  assign count_o       = out_count_q;
  assign top_item_o    = out_top_q;
  assign bottom_item_o = out_bottom_q;

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the byte stack with push, pop and peek commands.
`timescale 1ns / 1ps

module tb_top;

  // Generous cycle budget: about 630 items plus sender gaps and receiver
  // stalls, taken many times over.
  localparam int unsigned LimitCycles = 200000;
  // Cycles to let pass after the last result before touching the capacity.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxReported = 10;

  // One result item as the block reports it.
  typedef struct packed {
    logic [bsp_pkg::DataW-1:0]  data;
    logic [1:0]                 status;
    logic                       empty;
    logic                       full;
    logic [bsp_pkg::CountW-1:0] count;
    logic [bsp_pkg::DataW-1:0]  top;
    logic [bsp_pkg::DataW-1:0]  bottom;
  } stack_reply_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [1:0]                 command_i;
  logic [bsp_pkg::DataW-1:0]  value_i;
  logic [bsp_pkg::CountW-1:0] position_i;
  logic                       cfg_we_i;
  logic [bsp_pkg::CountW-1:0] cfg_wdata_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [bsp_pkg::DataW-1:0]  data_o;
  logic [1:0]                 status_o;
  logic                       empty_res_o;
  logic                       full_res_o;
  logic [bsp_pkg::CountW-1:0] count_o;
  logic [bsp_pkg::DataW-1:0]  top_item_o;
  logic [bsp_pkg::DataW-1:0]  bottom_item_o;

  // Mirror of the stack: entries, fill level and the raw capacity register.
  logic [bsp_pkg::DataW-1:0]  stack_mem [bsp_pkg::Depth];
  int unsigned                stack_fill;
  logic [bsp_pkg::CountW-1:0] stack_cap_reg;

  // Replies predicted for accepted items, oldest first.
  stack_reply_t      awaited_q[$];
  stack_reply_t      observed_reply;
  stack_reply_t      oldest_reply;

  int unsigned       err_count;
  int unsigned       cycle_count;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;

  byte_stack_with_peek DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_o       (data_o),
    .status_o     (status_o),
    .empty_res_o  (empty_res_o),
    .full_res_o   (full_res_o),
    .count_o      (count_o),
    .top_item_o   (top_item_o),
    .bottom_item_o(bottom_item_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Receiver side: stall at random at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Zero acts as one, anything above the depth saturates to it.
  function automatic int unsigned effective_capacity(logic [bsp_pkg::CountW-1:0] raw);
    if (raw == '0) return 1;
    if (raw > bsp_pkg::CountDepth) return bsp_pkg::Depth;
    return raw;
  endfunction

  // Apply one accepted item to the mirror and queue the reply it must produce.
  task automatic predict_stack_op(input logic [1:0] cmd,
                                  input logic [bsp_pkg::DataW-1:0] val,
                                  input logic [bsp_pkg::CountW-1:0] pos);
    stack_reply_t reply;
    int unsigned  cap;
    cap = effective_capacity(stack_cap_reg);
    reply = '0;
    reply.status = bsp_pkg::ST_OK;
    case (cmd)
      bsp_pkg::CMD_PUSH: begin
        if (stack_fill >= cap) begin
          reply.status = bsp_pkg::ST_OVERFLOW;
        end else begin
          stack_mem[stack_fill] = val;
          stack_fill++;
        end
      end
      bsp_pkg::CMD_POP: begin
        if (stack_fill == 0) begin
          reply.status = bsp_pkg::ST_UNDERFLOW;
        end else begin
          stack_fill--;
          reply.data = stack_mem[stack_fill];
        end
      end
      bsp_pkg::CMD_PEEK: begin
        // An empty stack reports underflow before the position is looked at.
        if (stack_fill == 0) begin
          reply.status = bsp_pkg::ST_UNDERFLOW;
        end else if (pos == '0 || pos > stack_fill) begin
          reply.status = bsp_pkg::ST_BADPOS;
        end else begin
          reply.data = stack_mem[stack_fill - pos];
        end
      end
      default: begin
      end
    endcase
    reply.empty  = (stack_fill == 0);
    reply.full   = (stack_fill >= cap);
    reply.count  = stack_fill[bsp_pkg::CountW-1:0];
    reply.top    = (stack_fill == 0) ? '0 : stack_mem[stack_fill - 1];
    reply.bottom = (stack_fill == 0) ? '0 : stack_mem[0];
    awaited_q.push_back(reply);
  endtask

  task automatic note_mismatch(input string what, input stack_reply_t exp_r,
                               input stack_reply_t got_r);
    err_count++;
    if (err_count <= MaxReported) begin
      $display("%0t %s: exp data=%h st=%0d empty=%b full=%b cnt=%0d top=%h bot=%h",
               $realtime, what, exp_r.data, exp_r.status, exp_r.empty, exp_r.full,
               exp_r.count, exp_r.top, exp_r.bottom);
      $display("%0t %s: got data=%h st=%0d empty=%b full=%b cnt=%0d top=%h bot=%h",
               $realtime, what, got_r.data, got_r.status, got_r.empty, got_r.full,
               got_r.count, got_r.top, got_r.bottom);
    end
  endtask

  // Compare every accepted result item with the oldest predicted reply.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      observed_reply = '{data_o, status_o, empty_res_o, full_res_o, count_o,
                         top_item_o, bottom_item_o};
      if (awaited_q.size() == 0) begin
        note_mismatch("unexpected item", '0, observed_reply);
      end else begin
        oldest_reply = awaited_q.pop_front();
        if (observed_reply !== oldest_reply) begin
          note_mismatch("mismatch", oldest_reply, observed_reply);
        end
      end
    end
  end

  // Drive one item and hold it until the block takes it. An optional gap with
  // valid low goes first; the payload is scrambled during the gap.
  task automatic send_stack_op(input logic [1:0] cmd,
                               input logic [bsp_pkg::DataW-1:0] val,
                               input logic [bsp_pkg::CountW-1:0] pos);
    int unsigned gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      command_i  <= 2'($urandom_range(3));
      value_i    <= 8'($urandom_range(255));
      position_i <= 6'($urandom_range(63));
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    position_i <= pos;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_stack_op(cmd, val, pos);
  endtask

  // Drop valid and hold off until every predicted reply has come back.
  task automatic wait_for_replies();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_q.size() != 0) @(posedge clk_i);
  endtask

  // Drain fully, let the pipeline settle, then write the capacity register.
  task automatic set_capacity(input logic [bsp_pkg::CountW-1:0] cap);
    wait_for_replies();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    stack_cap_reg = cap;
    cfg_we_i <= 1'b0;
  endtask

  // Empty-stack errors, extreme bytes, every peek position class and the no-op.
  task automatic test_empty_and_peek();
    send_stack_op(bsp_pkg::CMD_PEEK, 8'h00, 6'd1);
    send_stack_op(bsp_pkg::CMD_POP,  8'hFF, 6'd0);
    send_stack_op(bsp_pkg::CMD_PUSH, 8'h00, 6'd63);
    send_stack_op(bsp_pkg::CMD_PUSH, 8'hFF, 6'd0);
    send_stack_op(bsp_pkg::CMD_PEEK, 8'h00, 6'd0);
    send_stack_op(bsp_pkg::CMD_PEEK, 8'h00, 6'd1);
    send_stack_op(bsp_pkg::CMD_PEEK, 8'h00, 6'd2);
    send_stack_op(bsp_pkg::CMD_PEEK, 8'h00, 6'd3);
    send_stack_op(bsp_pkg::CMD_PEEK, 8'hFF, 6'd63);
    send_stack_op(bsp_pkg::CMD_NOP,  8'hFF, 6'd63);
    send_stack_op(bsp_pkg::CMD_POP,  8'h00, 6'd0);
    send_stack_op(bsp_pkg::CMD_POP,  8'h00, 6'd0);
    send_stack_op(bsp_pkg::CMD_POP,  8'h00, 6'd0);
  endtask

  // Capacity of one, zero acting as one, saturation above the depth, and a
  // capacity lowered below the current count.
  task automatic test_capacity_edges();
    set_capacity(6'd1);
    send_stack_op(bsp_pkg::CMD_PUSH, 8'h5A, 6'd0);
    send_stack_op(bsp_pkg::CMD_PUSH, 8'hA5, 6'd0);
    send_stack_op(bsp_pkg::CMD_PEEK, 8'h00, 6'd1);
    send_stack_op(bsp_pkg::CMD_POP,  8'h00, 6'd0);
    set_capacity(6'd0);
    send_stack_op(bsp_pkg::CMD_PUSH, 8'h3C, 6'd0);
    send_stack_op(bsp_pkg::CMD_PUSH, 8'hC3, 6'd0);
    set_capacity(6'd63);
    send_stack_op(bsp_pkg::CMD_PUSH, 8'h81, 6'd0);
    send_stack_op(bsp_pkg::CMD_PUSH, 8'h7E, 6'd0);
    set_capacity(6'd2);
    send_stack_op(bsp_pkg::CMD_PUSH, 8'h11, 6'd0);
    send_stack_op(bsp_pkg::CMD_PEEK, 8'h00, 6'd3);
    send_stack_op(bsp_pkg::CMD_POP,  8'h00, 6'd0);
  endtask

  // Random traffic in bursts: fill-heavy bursts reach full, drain-heavy ones
  // reach empty, mixed ones stir the middle. Peeks mostly hit valid depths.
  task automatic test_random_phase(input int unsigned n_items, input int unsigned idle_pct,
                                   input int unsigned stall_pct,
                                   input logic [bsp_pkg::CountW-1:0] cap);
    int unsigned                burst_left;
    int unsigned                mode;
    int unsigned                roll;
    logic [1:0]                 cmd;
    logic [bsp_pkg::CountW-1:0] pos;
    burst_left = 0;
    mode = 0;
    set_capacity(cap);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(8, 40);
        mode = $urandom_range(2);
      end
      burst_left--;
      roll = $urandom_range(99);
      case (mode)
        0: cmd = (roll < 75) ? bsp_pkg::CMD_PUSH : (roll < 85) ? bsp_pkg::CMD_POP :
                 (roll < 97) ? bsp_pkg::CMD_PEEK : bsp_pkg::CMD_NOP;
        1: cmd = (roll < 75) ? bsp_pkg::CMD_POP : (roll < 85) ? bsp_pkg::CMD_PUSH :
                 (roll < 97) ? bsp_pkg::CMD_PEEK : bsp_pkg::CMD_NOP;
        default: cmd = (roll < 35) ? bsp_pkg::CMD_PUSH : (roll < 65) ? bsp_pkg::CMD_POP :
                       (roll < 95) ? bsp_pkg::CMD_PEEK : bsp_pkg::CMD_NOP;
      endcase
      if (stack_fill != 0 && $urandom_range(99) < 80) begin
        pos = 6'($urandom_range(1, stack_fill));
      end else begin
        pos = 6'($urandom_range(63));
      end
      // Hold off now and then, and once mid-phase, until all replies are in.
      if (i == n_items / 2 || $urandom_range(99) == 0) begin
        wait_for_replies();
      end
      send_stack_op(cmd, 8'($urandom_range(255)), pos);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = bsp_pkg::CMD_NOP;
    value_i        = '0;
    position_i     = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    out_stall_i    = 1'b0;
    err_count      = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stack_fill     = 0;
    stack_cap_reg  = bsp_pkg::CapReset;
    foreach (stack_mem[k]) stack_mem[k] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_peek();
    test_capacity_edges();
    test_random_phase(150, 0, 0, 6'd32);
    test_random_phase(150, 59, 0, 6'd5);
    test_random_phase(150, 0, 59, 6'd63);
    test_random_phase(150, 36, 36, 6'($urandom_range(1, 32)));

    // Drain, then give the pipeline time to show any stray result item.
    wait_for_replies();
    repeat (SettleCycles) @(posedge clk_i);
    if (awaited_q.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("byte_stack_with_peek verification clean");
    end else begin
      $display("byte_stack_with_peek verification failed");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    wait (cycle_count >= LimitCycles);
    $display("byte_stack_with_peek verification failed");
    $finish;
  end

endmodule
